// ===== rtl/triangle_tangent_frame_top_defines.svh =====
// Assertion macros shared by the tangent frame RTL.
`ifndef TRIANGLE_TANGENT_FRAME_TOP_DEFINES_SVH
`define TRIANGLE_TANGENT_FRAME_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TFF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TFF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TFF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TFF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/tff_pkg.sv =====
// Types and constants of the triangle tangent frame block.
`timescale 1ns / 1ps
package tff_pkg;

  typedef struct packed {
    logic signed [15:0] position_x;
    logic signed [15:0] position_y;
    logic signed [15:0] position_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
  } tff_in_t;

  typedef struct packed {
    logic [1:0]         vertex_slot;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [15:0] bitangent_x;
    logic signed [15:0] bitangent_y;
    logic signed [15:0] bitangent_z;
    logic               degenerate;
    logic               last;
  } tff_out_t;

  localparam int TAN_LIMIT_BITS  = 20;
  localparam int PROJ_LIMIT_BITS = 16;
  localparam int FRAC_SHIFT      = 28;
  localparam int SQRT_STEPS      = 32;
  localparam int DIV_STEPS       = 45;

endpackage

// ===== rtl/tff_stream_if.sv =====
// Valid/ready stream interface carrying one word per handshake.
`timescale 1ns / 1ps
interface tff_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/triangle_tangent_frame_top.sv =====
// Per-triangle tangent frame by Gram-Schmidt on one shared multiply-accumulate unit.
// The first two vertices are stored as they arrive; the third starts the determinant,
// UV tangent and prescale, then per vertex prescale shifts, a 32-step square root, three
// divisions and the bitangent, or just the projection check if its projection is zero.
// A zero determinant goes straight to three flat results. Results wait until taken and the
// input waits for the last one; synchronous active-low reset idles the FSM, zeroes the count.
`timescale 1ns / 1ps
`include "triangle_tangent_frame_top_defines.svh"
module triangle_tangent_frame_top #(
  parameter int COORD_WIDTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  tff_stream_if.sink   in_stream,
  tff_stream_if.source out_stream
);

  localparam int CW = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DET   = 4'd1;
  localparam logic [3:0] ST_TAN   = 4'd2;
  localparam logic [3:0] ST_TSCL  = 4'd3;
  localparam logic [3:0] ST_DOT   = 4'd4;
  localparam logic [3:0] ST_PROJ  = 4'd5;
  localparam logic [3:0] ST_PCHK  = 4'd6;
  localparam logic [3:0] ST_PSCL  = 4'd7;
  localparam logic [3:0] ST_LEN   = 4'd8;
  localparam logic [3:0] ST_SQRT  = 4'd9;
  localparam logic [3:0] ST_DINIT = 4'd10;
  localparam logic [3:0] ST_DIV   = 4'd11;
  localparam logic [3:0] ST_BIT   = 4'd12;
  localparam logic [3:0] ST_OUT   = 4'd13;

  function automatic logic signed [16:0] sext_c(input logic [15:0] x);
    return signed'(17'({{(17 - CW){x[CW-1]}}, x[CW-1:0]}));
  endfunction

  logic [3:0]  state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [1:0]  vcount_r, vcount_nxt;
  logic [1:0]  vtx_r, vtx_nxt;
  logic [1:0]  ci_r;
  logic [15:0] held_r [16];
  logic [15:0] cur_r [8];
  logic [15:0] in_words [8];

  logic signed [55:0] acc_r;
  logic               det_neg_r, degall_r, deg_r;
  logic [35:0]        tmag_r [3];
  logic               tneg_r [3];
  logic signed [37:0] dot_r;
  logic [55:0]        pmag_r [3];
  logic               pneg_r [3];
  logic [62:0]        x_r, r_r, bit_r;
  logic [44:0]        num_r;
  logic [31:0]        rem_r;
  logic signed [15:0] t_r [3];
  logic signed [15:0] b_r [3];

  logic signed [16:0] du1, dv1, du2, dv2;
  logic signed [16:0] d1 [3];
  logic signed [16:0] d2 [3];
  logic signed [20:0] tsv [3];
  logic signed [15:0] nv [3];

  logic signed [39:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [57:0] prod;
  logic signed [55:0] base, res;
  logic               mneg;
  logic [55:0]        res_mag;
  logic [1:0]         k;
  logic               in_acc, out_acc;

  assign in_words[0] = in_stream.payload.position_x;
  assign in_words[1] = in_stream.payload.position_y;
  assign in_words[2] = in_stream.payload.position_z;
  assign in_words[3] = in_stream.payload.normal_x;
  assign in_words[4] = in_stream.payload.normal_y;
  assign in_words[5] = in_stream.payload.normal_z;
  assign in_words[6] = in_stream.payload.tex_u;
  assign in_words[7] = in_stream.payload.tex_v;

  assign in_stream.ready  = (state_r == ST_IDLE);
  assign in_acc  = in_stream.valid && in_stream.ready;
  assign out_stream.valid = (state_r == ST_OUT);
  assign out_acc = out_stream.valid && out_stream.ready;

  assign out_stream.payload.vertex_slot = vtx_r;
  assign out_stream.payload.tangent_x   = t_r[0];
  assign out_stream.payload.tangent_y   = t_r[1];
  assign out_stream.payload.tangent_z   = t_r[2];
  assign out_stream.payload.bitangent_x = b_r[0];
  assign out_stream.payload.bitangent_y = b_r[1];
  assign out_stream.payload.bitangent_z = b_r[2];
  assign out_stream.payload.degenerate  = deg_r;
  assign out_stream.payload.last        = (vtx_r == 2'd2);

  always_comb begin
    du1 = sext_c(held_r[14]) - sext_c(held_r[6]);
    dv1 = sext_c(held_r[15]) - sext_c(held_r[7]);
    du2 = sext_c(cur_r[6]) - sext_c(held_r[6]);
    dv2 = sext_c(cur_r[7]) - sext_c(held_r[7]);
    for (int i = 0; i < 3; i++) begin
      d1[i]  = sext_c(held_r[8 + i]) - sext_c(held_r[i]);
      d2[i]  = sext_c(cur_r[i]) - sext_c(held_r[i]);
      tsv[i] = tneg_r[i] ? -signed'({1'b0, tmag_r[i][19:0]})
                         : signed'({1'b0, tmag_r[i][19:0]});
      unique case (vtx_r)
        2'd0:    nv[i] = signed'(held_r[3 + i]);
        2'd1:    nv[i] = signed'(held_r[11 + i]);
        default: nv[i] = signed'(cur_r[3 + i]);
      endcase
    end
  end

  // Operand selection for the shared multiply-accumulate unit.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    base  = '0;
    mneg  = 1'b0;
    k     = cnt_r[2:1];
    case (state_r)
      ST_DET: begin
        if (cnt_r[0]) begin
          base = acc_r; mneg = 1'b1; mul_a = 40'(dv1); mul_b = 18'(du2);
        end else begin
          mul_a = 40'(du1); mul_b = 18'(dv2);
        end
      end
      ST_TAN: begin
        if (cnt_r[0]) begin
          base = acc_r; mneg = 1'b1; mul_a = 40'(d2[k]); mul_b = 18'(dv1);
        end else begin
          mul_a = 40'(d1[k]); mul_b = 18'(dv2);
        end
      end
      ST_DOT: begin
        base  = (cnt_r == 6'd0) ? '0 : acc_r;
        mul_a = 40'(tsv[cnt_r[1:0]]);
        mul_b = 18'(nv[cnt_r[1:0]]);
      end
      ST_PROJ: begin
        base  = signed'({{7{tsv[cnt_r[1:0]][20]}}, tsv[cnt_r[1:0]], 28'b0});
        mneg  = 1'b1;
        mul_a = 40'(dot_r);
        mul_b = 18'(nv[cnt_r[1:0]]);
      end
      ST_LEN: begin
        base  = (cnt_r == 6'd0) ? '0 : acc_r;
        mul_a = signed'({24'b0, pmag_r[cnt_r[1:0]][15:0]});
        mul_b = signed'({2'b0, pmag_r[cnt_r[1:0]][15:0]});
      end
      ST_BIT: begin
        if (cnt_r[0]) begin
          base = acc_r; mneg = 1'b1;
          unique case (k)
            2'd0:    begin mul_a = 40'(nv[2]); mul_b = 18'(t_r[1]); end
            2'd1:    begin mul_a = 40'(nv[0]); mul_b = 18'(t_r[2]); end
            default: begin mul_a = 40'(nv[1]); mul_b = 18'(t_r[0]); end
          endcase
        end else begin
          unique case (k)
            2'd0:    begin mul_a = 40'(nv[1]); mul_b = 18'(t_r[2]); end
            2'd1:    begin mul_a = 40'(nv[2]); mul_b = 18'(t_r[0]); end
            default: begin mul_a = 40'(nv[0]); mul_b = 18'(t_r[1]); end
          endcase
        end
      end
      default: begin
        mul_a = '0;
      end
    endcase
    prod    = mul_a * mul_b;
    res     = mneg ? (base - prod[55:0]) : (base + prod[55:0]);
    res_mag = res[55] ? 56'(-res) : 56'(res);
  end

  // Sequencer and datapath registers.
  logic [62:0] sq_rb;
  logic        sq_ge;
  logic [31:0] dv_sh;
  logic        dv_ge;
  logic [44:0] dv_q;
  logic [14:0] tq_mag;
  logic [33:0] br_round;
  logic [14:0] bq_mag;
  logic [55:0] p_or;
  logic [35:0] t_or;

  always_comb begin
    sq_rb    = r_r + bit_r;
    sq_ge    = (x_r >= sq_rb);
    dv_sh    = {rem_r[30:0], num_r[44]};
    dv_ge    = (dv_sh >= {1'b0, r_r[30:0]});
    dv_q     = {num_r[43:0], dv_ge};
    tq_mag   = (dv_q > 45'd16384) ? 15'd16384 : dv_q[14:0];
    br_round = res_mag[33:0] + 34'd8192;
    bq_mag   = (br_round[33:14] > 20'd16384) ? 15'd16384 : br_round[28:14];
    p_or     = pmag_r[0] | pmag_r[1] | pmag_r[2];
    t_or     = tmag_r[0] | tmag_r[1] | tmag_r[2];
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    vcount_nxt = vcount_r;
    vtx_nxt    = vtx_r;
    unique case (state_r) inside
      ST_IDLE: begin
        if (in_acc) begin
          if (vcount_r == 2'd2) begin
            vcount_nxt = 2'd0;
            state_nxt  = ST_DET;
            cnt_nxt    = '0;
          end else begin
            vcount_nxt = vcount_r + 2'd1;
          end
        end
      end
      ST_DET: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd1) begin
          cnt_nxt = '0;
          vtx_nxt = 2'd0;
          state_nxt = (res == '0) ? ST_OUT : ST_TAN;
        end
      end
      ST_TAN: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd5) begin
          cnt_nxt   = '0;
          state_nxt = ST_TSCL;
        end
      end
      ST_TSCL: begin
        if (t_or[35:tff_pkg::TAN_LIMIT_BITS] == '0) begin
          state_nxt = ST_DOT;
          vtx_nxt   = 2'd0;
        end
      end
      ST_DOT, ST_PROJ: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd2) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == ST_DOT) ? ST_PROJ : ST_PCHK;
        end
      end
      ST_PCHK: state_nxt = (p_or == '0) ? ST_OUT : ST_PSCL;
      ST_PSCL: begin
        if (p_or[55:tff_pkg::PROJ_LIMIT_BITS] == '0) state_nxt = ST_LEN;
      end
      ST_LEN: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd2) begin
          cnt_nxt   = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(tff_pkg::SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DINIT;
        end
      end
      ST_DINIT: state_nxt = ST_DIV;
      ST_DIV: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(tff_pkg::DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = (ci_r == 2'd2) ? ST_BIT : ST_DINIT;
        end
      end
      ST_BIT: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd5) begin
          cnt_nxt   = '0;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          if (vtx_r == 2'd2) begin
            state_nxt = ST_IDLE;
          end else begin
            vtx_nxt   = vtx_r + 2'd1;
            state_nxt = degall_r ? ST_OUT : ST_DOT;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      vcount_r <= '0;
      vtx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      vcount_r <= vcount_nxt;
      vtx_r    <= vtx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= res;
    case (state_r)
      ST_IDLE: begin
        degall_r <= 1'b0;
        if (in_acc) begin
          for (int i = 0; i < 8; i++) begin
            if (vcount_r == 2'd2) cur_r[i] <= in_words[i];
            else held_r[{vcount_r[0], 3'(i)}] <= in_words[i];
          end
        end
      end
      ST_DET: begin
        if (cnt_r[0]) begin
          det_neg_r <= res[55];
          if (res == '0) begin
            degall_r <= 1'b1;
            deg_r    <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              t_r[i] <= '0;
              b_r[i] <= '0;
            end
          end
        end
      end
      ST_TAN: begin
        if (cnt_r[0]) begin
          tmag_r[k] <= res_mag[35:0];
          tneg_r[k] <= res[55] ^ det_neg_r;
        end
      end
      ST_TSCL: begin
        if (t_or[35:tff_pkg::TAN_LIMIT_BITS] != '0) begin
          for (int i = 0; i < 3; i++) tmag_r[i] <= tmag_r[i] >> 1;
        end
      end
      ST_DOT: begin
        if (cnt_r == 6'd2) dot_r <= res[37:0];
      end
      ST_PROJ: begin
        pmag_r[cnt_r[1:0]] <= res_mag;
        pneg_r[cnt_r[1:0]] <= res[55];
      end
      ST_PCHK: begin
        if (p_or == '0) begin
          deg_r <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            t_r[i] <= '0;
            b_r[i] <= '0;
          end
        end
      end
      ST_PSCL: begin
        if (p_or[55:tff_pkg::PROJ_LIMIT_BITS] != '0) begin
          for (int i = 0; i < 3; i++) pmag_r[i] <= pmag_r[i] >> 1;
        end
      end
      ST_LEN: begin
        if (cnt_r == 6'd2) begin
          x_r   <= {1'b0, res[33:0], 28'b0};
          r_r   <= '0;
          bit_r <= {1'b1, 62'b0};
          ci_r  <= 2'd3;
        end
      end
      ST_SQRT: begin
        if (sq_ge) begin
          x_r <= x_r - sq_rb;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      ST_DINIT: begin
        ci_r  <= (ci_r == 2'd3) ? 2'd0 : ci_r + 2'd1;
        rem_r <= '0;
        num_r <= {1'b0, pmag_r[(ci_r == 2'd3) ? 2'd0 : ci_r + 2'd1][15:0], 28'b0}
                 + 45'(r_r[30:1]);
      end
      ST_DIV: begin
        rem_r <= dv_ge ? (dv_sh - {1'b0, r_r[30:0]}) : dv_sh;
        num_r <= dv_q;
        if (cnt_r == 6'(tff_pkg::DIV_STEPS - 1)) begin
          t_r[ci_r] <= pneg_r[ci_r] ? -signed'({1'b0, tq_mag}) : signed'({1'b0, tq_mag});
        end
      end
      ST_BIT: begin
        if (cnt_r[0]) begin
          b_r[k] <= res[55] ? -signed'({1'b0, bq_mag}) : signed'({1'b0, bq_mag});
          deg_r  <= 1'b0;
        end
      end
      default: begin
        deg_r <= deg_r;
      end
    endcase
  end

  `TFF_ASSERT_SAME(a_no_input_while_busy, clk, rst_n, out_stream.valid, !in_stream.ready)
  `TFF_ASSERT_NEXT(a_last_returns_idle, clk, rst_n,
    out_acc && out_stream.payload.last, in_stream.ready)
  `TFF_ASSERT_SAME(a_degenerate_zero, clk, rst_n,
    out_stream.valid && out_stream.payload.degenerate,
    out_stream.payload.tangent_x == 16'sd0 && out_stream.payload.bitangent_z == 16'sd0)
  `TFF_ASSERT_NEXT(a_third_vertex_starts, clk, rst_n,
    in_acc && vcount_r == 2'd2, !in_stream.ready && vcount_r == 2'd0)

endmodule
